FILE: rtl/r2fft_pkg.sv
// Shared constants, types, twiddle tables and helpers for the radix-2 FFT block.
package r2fft_pkg;

  localparam int POINTS      = 512;
  localparam int SAMPLE_BITS = 16;
  localparam int BIN_BITS    = 9;
  localparam int VAL_BITS    = 26;
  localparam int TW_BITS     = 17;
  localparam int Q_SHIFT     = 15;
  localparam int ADDR_W      = $clog2(POINTS);
  localparam int BF_W        = ADDR_W - 1;
  localparam int STG_W       = $clog2(ADDR_W);
  localparam int WORD_W      = 2 * VAL_BITS;
  localparam int PROD_W      = TW_BITS + VAL_BITS;
  localparam int SUM_W       = PROD_W + 1;
  localparam int TW_DEPTH    = POINTS / 2;
  localparam real PI_R       = 3.14159265358979323846;
  localparam real Q_ONE      = 32768.0;

  // Datapath operation codes, one per cycle.
  localparam logic [3:0] OP_IDLE   = 4'd0;
  localparam logic [3:0] OP_CAP_A  = 4'd1;
  localparam logic [3:0] OP_CAP_B  = 4'd2;
  localparam logic [3:0] OP_MUL_RR = 4'd3;
  localparam logic [3:0] OP_MUL_II = 4'd4;
  localparam logic [3:0] OP_MUL_RI = 4'd5;
  localparam logic [3:0] OP_MUL_IR = 4'd6;
  localparam logic [3:0] OP_FIN_IM = 4'd7;
  localparam logic [3:0] OP_OUT    = 4'd8;

  // Write data selection codes.
  localparam logic [2:0] WS_LOAD = 3'd0;
  localparam logic [2:0] WS_SUM  = 3'd1;
  localparam logic [2:0] WS_DIF  = 3'd2;
  localparam logic [2:0] WS_A    = 3'd3;
  localparam logic [2:0] WS_B    = 3'd4;

  typedef logic signed [TW_BITS-1:0] tw_tab_t [TW_DEPTH];

  // Command bundle from the controller to the datapath.
  typedef struct packed {
    logic [3:0]        op;
    logic              we;
    logic [2:0]        wsel;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [BF_W-1:0]   tw_idx;
    logic              out_zero;
  } cmd_t;

  // Twiddle table exp(-2*pi*i*k/POINTS) in Q2.15, rounded to nearest.
  function automatic tw_tab_t tw_build(input bit imag);
    tw_tab_t t;
    real     ang;
    real     x;
    for (int k = 0; k < TW_DEPTH; k++) begin
      ang = 2.0 * PI_R * k / POINTS;
      x   = imag ? -$sin(ang) : $cos(ang);
      t[k] = TW_BITS'($rtoi($floor(x * Q_ONE + 0.5)));
    end
    return t;
  endfunction

  localparam tw_tab_t TW_RE = tw_build(1'b0);
  localparam tw_tab_t TW_IM = tw_build(1'b1);

  // Bit-reversed address.
  function automatic logic [ADDR_W-1:0] bitrev(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    for (int b = 0; b < ADDR_W; b++) begin
      r[ADDR_W-1-b] = a[b];
    end
    return r;
  endfunction

endpackage

FILE: rtl/r2fft_ram.sv
// Generic single-write, single-read RAM with registered read data.
module r2fft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/r2fft_dp.sv
// Datapath: point store, butterfly multiplier and adders, output registers.
module r2fft_dp (
  input  logic                              clk_i,
  input  r2fft_pkg::cmd_t                   cmd_i,
  input  logic signed [r2fft_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic signed [r2fft_pkg::VAL_BITS-1:0]    bin_real_o,
  output logic signed [r2fft_pkg::VAL_BITS-1:0]    bin_imag_o
);
  import r2fft_pkg::*;

  logic [WORD_W-1:0]         rdata;
  logic [WORD_W-1:0]         wdata;
  logic [WORD_W-1:0]         a_q;
  logic [WORD_W-1:0]         b_q;
  logic signed [TW_BITS-1:0] wr_q;
  logic signed [TW_BITS-1:0] wi_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [PROD_W-1:0]  acc_q;
  logic [VAL_BITS-1:0]       vr_q;
  logic [VAL_BITS-1:0]       vi_q;
  logic signed [VAL_BITS-1:0] out_re_q;
  logic signed [VAL_BITS-1:0] out_im_q;
  logic signed [TW_BITS-1:0]  mul_a;
  logic signed [VAL_BITS-1:0] mul_b;
  logic signed [VAL_BITS-1:0] b_re;
  logic signed [VAL_BITS-1:0] b_im;
  logic [VAL_BITS-1:0]       a_re;
  logic [VAL_BITS-1:0]       a_im;
  logic signed [SUM_W-1:0]   diff;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   diff_sh;
  logic signed [SUM_W-1:0]   sum_sh;
  logic [VAL_BITS-1:0]       samp_ext;

  r2fft_ram #(
    .WIDTH(WORD_W),
    .DEPTH(POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.we),
    .waddr_i (cmd_i.waddr),
    .wdata_i (wdata),
    .raddr_i (cmd_i.raddr),
    .rdata_o (rdata)
  );

  assign a_re = a_q[WORD_W-1:VAL_BITS];
  assign a_im = a_q[VAL_BITS-1:0];
  assign b_re = b_q[WORD_W-1:VAL_BITS];
  assign b_im = b_q[VAL_BITS-1:0];
  assign samp_ext = {{(VAL_BITS-SAMPLE_BITS){sample_i[SAMPLE_BITS-1]}}, sample_i};

  // Operand selection for the shared multiplier.
  assign mul_a = (cmd_i.op == OP_MUL_RR || cmd_i.op == OP_MUL_RI) ? wr_q : wi_q;
  assign mul_b = (cmd_i.op == OP_MUL_RR || cmd_i.op == OP_MUL_IR) ? b_re : b_im;

  // Floor-shifted real and imaginary parts of the twiddled operand.
  assign diff    = {acc_q[PROD_W-1], acc_q} - {prod_q[PROD_W-1], prod_q};
  assign sum     = {acc_q[PROD_W-1], acc_q} + {prod_q[PROD_W-1], prod_q};
  assign diff_sh = diff >>> Q_SHIFT;
  assign sum_sh  = sum >>> Q_SHIFT;

  // Store write data.
  always_comb begin
    unique case (cmd_i.wsel)
      WS_LOAD: wdata = {samp_ext, {VAL_BITS{1'b0}}};
      WS_SUM:  wdata = {a_re + vr_q, a_im + vi_q};
      WS_DIF:  wdata = {a_re - vr_q, a_im - vi_q};
      WS_A:    wdata = a_q;
      WS_B:    wdata = b_q;
      default: wdata = a_q;
    endcase
  end

  // Butterfly and output registers.
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a * mul_b);
    unique case (cmd_i.op)
      OP_CAP_A: begin
        a_q  <= rdata;
        wr_q <= TW_RE[cmd_i.tw_idx];
        wi_q <= TW_IM[cmd_i.tw_idx];
      end
      OP_CAP_B:  b_q   <= rdata;
      OP_MUL_II: acc_q <= prod_q;
      OP_MUL_RI: vr_q  <= diff_sh[VAL_BITS-1:0];
      OP_MUL_IR: acc_q <= prod_q;
      OP_FIN_IM: vi_q  <= sum_sh[VAL_BITS-1:0];
      OP_OUT: begin
        out_re_q <= cmd_i.out_zero ? '0 : rdata[WORD_W-1:VAL_BITS];
        out_im_q <= cmd_i.out_zero ? '0 : rdata[VAL_BITS-1:0];
      end
      default: ;
    endcase
  end

  assign bin_real_o = out_re_q;
  assign bin_imag_o = out_im_q;

endmodule

FILE: rtl/r2fft_ctrl.sv
// Controller: handshakes, load counter, bit-reverse pass and butterfly sequencer.
module r2fft_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             kind_i,
  input  logic [r2fft_pkg::BIN_BITS-1:0]   bin_index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             transform_done_o,
  output r2fft_pkg::cmd_t                  cmd_o
);
  import r2fft_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDOUT = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_RA    = 4'd3;
  localparam logic [3:0] S_RB    = 4'd4;
  localparam logic [3:0] S_CB    = 4'd5;
  localparam logic [3:0] S_M1    = 4'd6;
  localparam logic [3:0] S_M2    = 4'd7;
  localparam logic [3:0] S_M3    = 4'd8;
  localparam logic [3:0] S_M4    = 4'd9;
  localparam logic [3:0] S_M5    = 4'd10;
  localparam logic [3:0] S_WA    = 4'd11;
  localparam logic [3:0] S_WB    = 4'd12;

  localparam logic [ADDR_W-1:0] LAST_POS   = ADDR_W'(POINTS - 1);
  localparam logic [BF_W-1:0]   LAST_BF    = BF_W'(POINTS / 2 - 1);
  localparam logic [STG_W-1:0]  LAST_STAGE = STG_W'(ADDR_W - 1);

  logic [3:0]        state_q, state_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [ADDR_W-1:0] i_q, i_d;
  logic [BF_W-1:0]   bf_q, bf_d;
  logic [STG_W-1:0]  stage_q, stage_d;
  logic              fft_q, fft_d;
  logic              done_q, done_d;
  logic              full_q, full_d;
  logic              rz_q, rz_d;
  logic              ov_q, ov_d;
  logic              accept;
  logic [ADDR_W-1:0] bin_addr;
  logic [ADDR_W-1:0] rev_i;
  logic [BF_W-1:0]   lo_mask;
  logic [ADDR_W-1:0] fft_a;
  logic [ADDR_W-1:0] fft_b;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [BF_W-1:0]   tw_idx;

  assign in_ready_o       = (state_q == S_IDLE) && (!ov_q || out_ready_i);
  assign accept           = in_valid_i && in_ready_o;
  assign out_valid_o      = ov_q;
  assign transform_done_o = done_q;
  assign bin_addr         = ADDR_W'(bin_index_i);
  assign rev_i            = bitrev(i_q);

  // Butterfly addresses and twiddle index for the current stage.
  assign lo_mask = ~({BF_W{1'b1}} << stage_q);
  assign fft_a   = {bf_q & ~lo_mask, 1'b0} | {1'b0, bf_q & lo_mask};
  assign fft_b   = fft_a | (ADDR_W'(1) << stage_q);
  assign tw_idx  = (bf_q & lo_mask) << (LAST_STAGE - stage_q);
  assign addr_a  = fft_q ? fft_a : i_q;
  assign addr_b  = fft_q ? fft_b : rev_i;

  // Next state, counters and commands.
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    i_d     = i_q;
    bf_d    = bf_q;
    stage_d = stage_q;
    fft_d   = fft_q;
    done_d  = done_q;
    full_d  = full_q;
    rz_d    = rz_q;
    ov_d    = ov_q && !out_ready_i;
    cmd_o          = '0;
    cmd_o.op       = OP_IDLE;
    cmd_o.wsel     = WS_LOAD;
    cmd_o.raddr    = addr_a;
    cmd_o.waddr    = addr_a;
    cmd_o.tw_idx   = tw_idx;
    cmd_o.out_zero = rz_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.raddr = bin_addr;
        if (accept && kind_i) begin
          rz_d    = !full_q && (bin_addr >= pos_q);
          state_d = S_RDOUT;
        end else if (accept) begin
          cmd_o.we    = 1'b1;
          cmd_o.waddr = pos_q;
          if (pos_q == '0) begin
            done_d = 1'b0;
          end
          pos_d = pos_q + 1'b1;
          if (pos_q == LAST_POS) begin
            i_d     = '0;
            fft_d   = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_RDOUT: begin
        cmd_o.op = OP_OUT;
        ov_d     = 1'b1;
        state_d  = S_IDLE;
      end
      S_SCAN: begin
        if (i_q < rev_i) begin
          state_d = S_RA;
        end else if (i_q == LAST_POS) begin
          fft_d   = 1'b1;
          stage_d = '0;
          bf_d    = '0;
          state_d = S_RA;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_RA: state_d = S_RB;
      S_RB: begin
        cmd_o.raddr = addr_b;
        cmd_o.op    = OP_CAP_A;
        state_d     = S_CB;
      end
      S_CB: begin
        cmd_o.op = OP_CAP_B;
        state_d  = fft_q ? S_M1 : S_WA;
      end
      S_M1: begin
        cmd_o.op = OP_MUL_RR;
        state_d  = S_M2;
      end
      S_M2: begin
        cmd_o.op = OP_MUL_II;
        state_d  = S_M3;
      end
      S_M3: begin
        cmd_o.op = OP_MUL_RI;
        state_d  = S_M4;
      end
      S_M4: begin
        cmd_o.op = OP_MUL_IR;
        state_d  = S_M5;
      end
      S_M5: begin
        cmd_o.op = OP_FIN_IM;
        state_d  = S_WA;
      end
      S_WA: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = fft_q ? WS_SUM : WS_B;
        state_d    = S_WB;
      end
      S_WB: begin
        cmd_o.we    = 1'b1;
        cmd_o.waddr = addr_b;
        cmd_o.wsel  = fft_q ? WS_DIF : WS_A;
        if (!fft_q) begin
          i_d     = i_q + 1'b1;
          state_d = S_SCAN;
        end else if (bf_q != LAST_BF) begin
          bf_d    = bf_q + 1'b1;
          state_d = S_RA;
        end else if (stage_q != LAST_STAGE) begin
          bf_d    = '0;
          stage_d = stage_q + 1'b1;
          state_d = S_RA;
        end else begin
          done_d  = 1'b1;
          full_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= '0;
      i_q     <= '0;
      bf_q    <= '0;
      stage_q <= '0;
      fft_q   <= 1'b0;
      done_q  <= 1'b0;
      full_q  <= 1'b0;
      rz_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      i_q     <= i_d;
      bf_q    <= bf_d;
      stage_q <= stage_d;
      fft_q   <= fft_d;
      done_q  <= done_d;
      full_q  <= full_d;
      rz_q    <= rz_d;
      ov_q    <= ov_d;
    end
  end

endmodule

FILE: rtl/radix2_complex_fft.sv
// Top level of the 512-point radix-2 decimation-in-time FFT block.
//
//  Channel | Direction | Handshake              | Payload
//  in      | input     | in_valid_i/in_ready_o  | kind_i, sample_i, bin_index_i
//  out     | output    | out_valid_o/out_ready_i| bin_real_o, bin_imag_o, transform_done_o
//
// A load beat is written as it is accepted; a read beat keeps the block busy in S_RDOUT and
// its result is registered, with out_valid_o, as that state ends.
// The last load of a frame starts a bit-reverse pass swapping each mirrored address pair,
// then N/2*log2(N) butterflies share one multiplier and the single store read port;
// the block takes no new input until the transform is done.
// After reset a read of a position not yet loaded returns zero until the first transform is done; no clearing pass.
// Input is not taken while a result waits and the output side stalls.
module radix2_complex_fft (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic                                     kind_i,
  input  logic signed [r2fft_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic [r2fft_pkg::BIN_BITS-1:0]           bin_index_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [r2fft_pkg::VAL_BITS-1:0]    bin_real_o,
  output logic signed [r2fft_pkg::VAL_BITS-1:0]    bin_imag_o,
  output logic                                     transform_done_o
);
  import r2fft_pkg::*;

  cmd_t cmd;

  r2fft_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .bin_index_i      (bin_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .transform_done_o (transform_done_o),
    .cmd_o            (cmd)
  );

  r2fft_dp u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .sample_i   (sample_i),
    .bin_real_o (bin_real_o),
    .bin_imag_o (bin_imag_o)
  );

endmodule

FILE: rtl/r2fft_checker.sv
// Port-level assertions for the FFT block and the bind that attaches them.
module r2fft_checker (
  input logic                                     clk_i,
  input logic                                     rst_ni,
  input logic                                     in_valid_i,
  input logic                                     in_ready_o,
  input logic                                     kind_i,
  input logic signed [r2fft_pkg::SAMPLE_BITS-1:0] sample_i,
  input logic [r2fft_pkg::BIN_BITS-1:0]           bin_index_i,
  input logic                                     out_valid_o,
  input logic                                     out_ready_i,
  input logic signed [r2fft_pkg::VAL_BITS-1:0]    bin_real_o,
  input logic signed [r2fft_pkg::VAL_BITS-1:0]    bin_imag_o,
  input logic                                     transform_done_o
);

  // A waiting result holds its beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bin_real_o) && $stable(bin_imag_o))
    else $error("stalled result changed");

  // No input is taken while a result is stuck.
  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input ready while output stalled");

  // A read beat occupies the block for its lookup.
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i |=> !in_ready_o)
    else $error("ready during read lookup");

  // The done flag drops only on a load beat.
  a_done_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(transform_done_o) |-> $past(in_valid_i && in_ready_o && !kind_i))
    else $error("done flag cleared without a load");

  // The done flag rises only with no result pending.
  a_done_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(transform_done_o) |-> !out_valid_o)
    else $error("done flag rose with a result pending");

endmodule

bind radix2_complex_fft r2fft_checker u_r2fft_checker (.*);
